FILE: rtl/tpps_pkg.sv
// Package for the pick-and-place sequencer: types, codes, positions and phase waits.
`timescale 1ns / 1ps
package tpps_pkg;

  // Operation codes of an input transaction; code three does nothing beyond latching the button events as pending.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  localparam logic [1:0] LVL_INVALID = 2'd3;

  // Pending button event bits.
  localparam int unsigned EV_HEIGHT = 0;
  localparam int unsigned EV_ROTATE = 1;
  localparam int unsigned EV_PUMP   = 2;

  // Axis enable bits.
  localparam int unsigned AX_LIFT   = 0;
  localparam int unsigned AX_ROTATE = 1;
  localparam int unsigned AX_PUSH   = 2;

  localparam int HeightW = 12;
  localparam int RotW    = 9;
  localparam int PushW   = 8;
  localparam int WaitW   = 12;
  localparam int LenW    = 16;

  localparam logic signed [HeightW-1:0] H_LOW     = -12'sd300;
  localparam logic signed [HeightW-1:0] H_MID     = 12'sd400;
  localparam logic signed [HeightW-1:0] H_HIGH    = 12'sd1050;
  localparam logic signed [HeightW-1:0] H_RELEASE = 12'sd800;
  localparam logic [RotW-1:0]  ROT_HOME   = 9'd0;
  localparam logic [RotW-1:0]  ROT_TURNED = 9'd320;
  localparam logic [PushW-1:0] PUSH_IN    = 8'd0;
  localparam logic [PushW-1:0] PUSH_OUT   = 8'd250;

  localparam logic [WaitW-1:0] WAIT_HEIGHT     = 12'd600;
  localparam logic [WaitW-1:0] WAIT_ROTATE     = 12'd300;
  localparam logic [WaitW-1:0] WAIT_PUSH       = 12'd500;
  localparam logic [WaitW-1:0] WAIT_REL_HEIGHT = 12'd600;
  localparam logic [WaitW-1:0] WAIT_ROT_BACK   = 12'd900;
  localparam logic [WaitW-1:0] WAIT_RELEASE    = 12'd250;
  localparam logic [WaitW-1:0] RETREAT_MIN     = 12'd300;
  localparam logic [WaitW-1:0] RETREAT_MAX     = 12'd2500;
  localparam logic [WaitW-1:0] RETREAT_RST     = 12'd600;
  localparam logic [LenW-1:0]  LEN_MIN         = 16'd50;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_HEIGHT     = 3'd1,
    PH_ROTATE     = 3'd2,
    PH_PUSH       = 3'd3,
    PH_RETREAT    = 3'd4,
    PH_REL_HEIGHT = 3'd5,
    PH_ROT_BACK   = 3'd6,
    PH_RELEASE    = 3'd7
  } phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [1:0]  level;
    logic [2:0]  events;
  } item_t;

  typedef struct packed {
    phase_e                     phase;
    logic [31:0]                start_ms;
    logic [1:0]                 catch_code;
    logic [1:0]                 height_cycle;
    logic                       rotate_toggle;
    logic                       pump_toggle;
    logic [2:0]                 pending;
    logic signed [HeightW-1:0]  height_ref;
    logic [RotW-1:0]            rotate_ref;
    logic [PushW-1:0]           push_ref;
    logic [2:0]                 axis_enable;
    logic                       pump_on;
    logic                       retreat_on;
  } state_t;

  function automatic logic signed [HeightW-1:0] height_of(input logic [1:0] code);
    logic signed [HeightW-1:0] h;
    case (code)
      2'd0:    h = H_LOW;
      2'd1:    h = H_MID;
      default: h = H_HIGH;
    endcase
    return h;
  endfunction

endpackage

FILE: rtl/timed_pick_and_place_sequencer_core.sv
// Top level of the timed pick-and-place arm sequencer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction: an op (tick, start,
//   abort), the millisecond timestamp now_ms_i, the start level and three button events.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   transaction: all drive targets and enables, pump and retreat commands, the phase,
//   busy and the start-accepted flag, as they stand after that transaction.
//   A transaction moves when valid is high and stall is low at a rising edge.
//   Path: input register, then result register, with one short
//   compare-and-select pass (one 32-bit elapsed-time subtract and compare) between.
//   Throughput: one transaction per cycle, back to back, while the receiver does not stall;
//   the sequencer state updates in the same cycle that a result is loaded, so the next transaction sees it at once.
//   When the receiver stalls, the result register holds; the input register still takes
//   one more transaction, and only then stall is raised toward the sender.
//   cfg_we_i/cfg_wdata_i write the retreat length (clamped to at least 50 mm); the retreat time,
//   4 ms per mm limited to 300..2500 ms, is worked out at the write. Write only while idle.
//   Reset (rst_ni low, asynchronous) clears both registers, returns the phase to idle,
//   drops all pending events, turns axes, pump and retreat off and sets length 150 mm.
module timed_pick_and_place_sequencer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [tpps_pkg::LenW-1:0]           cfg_wdata_i,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic [31:0]                         now_ms_i,
  input  logic [1:0]                          level_i,
  input  logic                                height_event_i,
  input  logic                                rotate_event_i,
  input  logic                                pump_event_i,
  // result transactions
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tpps_pkg::HeightW-1:0] height_ref_o,
  output logic [tpps_pkg::RotW-1:0]           rotate_ref_o,
  output logic [tpps_pkg::PushW-1:0]          push_ref_o,
  output logic [2:0]                          axis_enable_o,
  output logic                                pump_on_o,
  output logic                                retreat_on_o,
  output logic [2:0]                          phase_o,
  output logic                                busy_res_o,
  output logic                                accepted_o
);

  logic [tpps_pkg::WaitW-1:0] retreat_ms;

  logic             in_vld_d, in_vld_q;
  tpps_pkg::item_t  item_q;
  logic             out_vld_d, out_vld_q;
  tpps_pkg::state_t st_q, st_nxt;
  logic             acc_nxt, acc_q;

  logic in_take;   // input transaction accepted
  logic out_free;  // result register can load this cycle
  logic fire;      // input register item processed this cycle

  tpps_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .retreat_ms_o (retreat_ms)
  );

  tpps_step u_step (
    .cur_i        (st_q),
    .item_i       (item_q),
    .retreat_ms_i (retreat_ms),
    .nxt_o        (st_nxt),
    .accepted_o   (acc_nxt)
  );

  // Handshake: the result register frees up when empty or when its result leaves.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take || (in_vld_q && !fire);
  assign out_vld_d = fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Hold the incoming transaction until it is processed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{op: op_i, now_ms: now_ms_i, level: level_i,
                  events: {pump_event_i, rotate_event_i, height_event_i}};
    end
  end

  // Sequencer state advances only on a processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: tpps_pkg::PH_IDLE, start_ms: '0, catch_code: '0,
                height_cycle: '0, rotate_toggle: 1'b0, pump_toggle: 1'b0,
                pending: '0, height_ref: '0, rotate_ref: '0, push_ref: '0,
                axis_enable: '0, pump_on: 1'b0, retreat_on: 1'b0};
    end else if (fire) begin
      st_q <= st_nxt;
    end
  end

  // The result payload is the state after the transaction plus its accept flag.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q <= acc_nxt;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign height_ref_o  = st_q.height_ref;
  assign rotate_ref_o  = st_q.rotate_ref;
  assign push_ref_o    = st_q.push_ref;
  assign axis_enable_o = st_q.axis_enable;
  assign pump_on_o     = st_q.pump_on;
  assign retreat_on_o  = st_q.retreat_on;
  assign phase_o       = st_q.phase;
  assign busy_res_o    = (st_q.phase != tpps_pkg::PH_IDLE);
  assign accepted_o    = acc_q;

  // Retreat command is only ever up while the vehicle retreat phase runs.
  a_retreat_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.retreat_on |-> st_q.phase == tpps_pkg::PH_RETREAT)
    else $error("retreat on outside the retreat phase");

  // An accepted start always lands in the first phase.
  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && acc_q |-> st_q.phase == tpps_pkg::PH_HEIGHT)
    else $error("accepted start did not enter the height phase");

  // A held input transaction is not dropped while the result side is blocked.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_free |=> in_vld_q && $stable(item_q))
    else $error("stalled input transaction lost");

  // State changes only when a transaction is processed.
  a_state_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(st_q))
    else $error("sequencer state changed without a transaction");

endmodule

FILE: rtl/tpps_cfg.sv
// Retreat length register: clamps the written length and holds the retreat time in ms.
`timescale 1ns / 1ps
module tpps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tpps_pkg::LenW-1:0]     cfg_wdata_i,
  output logic [tpps_pkg::WaitW-1:0]    retreat_ms_o
);

  logic [tpps_pkg::LenW-1:0]   len;
  logic [tpps_pkg::LenW+1:0]   ms;
  logic [tpps_pkg::WaitW-1:0]  retreat_ms_d, retreat_ms_q;

  always_comb begin
    len = (cfg_wdata_i < tpps_pkg::LEN_MIN) ? tpps_pkg::LEN_MIN : cfg_wdata_i;
    ms  = {len, 2'b00};
    if (ms < {{(tpps_pkg::LenW + 2 - tpps_pkg::WaitW){1'b0}}, tpps_pkg::RETREAT_MIN}) begin
      retreat_ms_d = tpps_pkg::RETREAT_MIN;
    end else if (ms > {{(tpps_pkg::LenW + 2 - tpps_pkg::WaitW){1'b0}},
                       tpps_pkg::RETREAT_MAX}) begin
      retreat_ms_d = tpps_pkg::RETREAT_MAX;
    end else begin
      retreat_ms_d = ms[tpps_pkg::WaitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retreat_ms_q <= tpps_pkg::RETREAT_RST;
    end else if (cfg_we_i) begin
      retreat_ms_q <= retreat_ms_d;
    end
  end

  assign retreat_ms_o = retreat_ms_q;

endmodule

FILE: rtl/tpps_step.sv
// Next-state logic of the sequencer for one transaction: phases, manual events, start, abort.
`timescale 1ns / 1ps
module tpps_step (
  input  tpps_pkg::state_t              cur_i,
  input  tpps_pkg::item_t               item_i,
  input  logic [tpps_pkg::WaitW-1:0]    retreat_ms_i,
  output tpps_pkg::state_t              nxt_o,
  output logic                          accepted_o
);

  logic [31:0]                 elapsed;
  logic [tpps_pkg::WaitW-1:0]  wait_ms;
  logic                        done;
  logic [2:0]                  pend;

  // Wait of the current phase, then one subtract and compare.
  always_comb begin
    unique case (cur_i.phase)
      tpps_pkg::PH_HEIGHT:     wait_ms = tpps_pkg::WAIT_HEIGHT;
      tpps_pkg::PH_ROTATE:     wait_ms = tpps_pkg::WAIT_ROTATE;
      tpps_pkg::PH_PUSH:       wait_ms = tpps_pkg::WAIT_PUSH;
      tpps_pkg::PH_RETREAT:    wait_ms = retreat_ms_i;
      tpps_pkg::PH_REL_HEIGHT: wait_ms = tpps_pkg::WAIT_REL_HEIGHT;
      tpps_pkg::PH_ROT_BACK:   wait_ms = tpps_pkg::WAIT_ROT_BACK;
      tpps_pkg::PH_RELEASE:    wait_ms = tpps_pkg::WAIT_RELEASE;
      default:                 wait_ms = '0;
    endcase
    elapsed = item_i.now_ms - cur_i.start_ms;
    done    = elapsed >= {{(32 - tpps_pkg::WaitW){1'b0}}, wait_ms};
  end

  always_comb begin
    pend       = cur_i.pending | item_i.events;
    nxt_o      = cur_i;
    nxt_o.pending = pend;
    accepted_o = 1'b0;
    case (item_i.op)
      tpps_pkg::OP_TICK: begin
        if (cur_i.phase != tpps_pkg::PH_IDLE) begin
          unique case (cur_i.phase)
            tpps_pkg::PH_HEIGHT: begin
              nxt_o.axis_enable[tpps_pkg::AX_LIFT] = 1'b1;
              nxt_o.height_ref = tpps_pkg::height_of(cur_i.catch_code);
              if (done) begin
                nxt_o.phase    = tpps_pkg::PH_ROTATE;
                nxt_o.start_ms = item_i.now_ms;
              end
            end
            tpps_pkg::PH_ROTATE: begin
              nxt_o.axis_enable[tpps_pkg::AX_ROTATE] = 1'b1;
              nxt_o.rotate_ref = tpps_pkg::ROT_TURNED;
              nxt_o.pump_on    = 1'b1;
              if (done) begin
                nxt_o.phase    = tpps_pkg::PH_PUSH;
                nxt_o.start_ms = item_i.now_ms;
              end
            end
            tpps_pkg::PH_PUSH: begin
              nxt_o.axis_enable[tpps_pkg::AX_PUSH] = 1'b1;
              nxt_o.push_ref = tpps_pkg::PUSH_OUT;
              if (done) begin
                nxt_o.retreat_on = 1'b1;
                nxt_o.phase      = tpps_pkg::PH_RETREAT;
                nxt_o.start_ms   = item_i.now_ms;
              end
            end
            tpps_pkg::PH_RETREAT: begin
              nxt_o.retreat_on = !done;
              if (done) begin
                nxt_o.phase    = tpps_pkg::PH_REL_HEIGHT;
                nxt_o.start_ms = item_i.now_ms;
              end
            end
            tpps_pkg::PH_REL_HEIGHT: begin
              nxt_o.axis_enable[tpps_pkg::AX_LIFT] = 1'b1;
              nxt_o.height_ref = tpps_pkg::H_RELEASE;
              if (done) begin
                nxt_o.phase    = tpps_pkg::PH_ROT_BACK;
                nxt_o.start_ms = item_i.now_ms;
              end
            end
            tpps_pkg::PH_ROT_BACK: begin
              nxt_o.axis_enable[tpps_pkg::AX_ROTATE] = 1'b1;
              nxt_o.rotate_ref = tpps_pkg::ROT_HOME;
              if (done) begin
                nxt_o.phase    = tpps_pkg::PH_RELEASE;
                nxt_o.start_ms = item_i.now_ms;
              end
            end
            default: begin
              nxt_o.axis_enable[tpps_pkg::AX_PUSH] = 1'b1;
              nxt_o.push_ref = tpps_pkg::PUSH_IN;
              nxt_o.pump_on  = 1'b0;
              if (done) begin
                nxt_o.retreat_on = 1'b0;
                nxt_o.phase      = tpps_pkg::PH_IDLE;
              end
            end
          endcase
        end else begin
          // Idle tick: consume every pending button event.
          if (pend[tpps_pkg::EV_HEIGHT]) begin
            nxt_o.axis_enable[tpps_pkg::AX_LIFT] = 1'b1;
            nxt_o.height_ref   = tpps_pkg::height_of(cur_i.height_cycle);
            nxt_o.height_cycle = (cur_i.height_cycle >= 2'd2) ? 2'd0
                                                              : cur_i.height_cycle + 2'd1;
          end
          if (pend[tpps_pkg::EV_ROTATE]) begin
            nxt_o.axis_enable[tpps_pkg::AX_ROTATE] = 1'b1;
            nxt_o.rotate_ref    = cur_i.rotate_toggle ? tpps_pkg::ROT_TURNED
                                                      : tpps_pkg::ROT_HOME;
            nxt_o.rotate_toggle = !cur_i.rotate_toggle;
          end
          if (pend[tpps_pkg::EV_PUMP]) begin
            nxt_o.pump_toggle = !cur_i.pump_toggle;
            nxt_o.pump_on     = !cur_i.pump_toggle;
          end
          nxt_o.pending = '0;
        end
      end
      tpps_pkg::OP_START: begin
        if (cur_i.phase == tpps_pkg::PH_IDLE && item_i.level != tpps_pkg::LVL_INVALID) begin
          nxt_o.catch_code = item_i.level;
          nxt_o.retreat_on = 1'b0;
          nxt_o.phase      = tpps_pkg::PH_HEIGHT;
          nxt_o.start_ms   = item_i.now_ms;
          accepted_o       = 1'b1;
        end
      end
      tpps_pkg::OP_ABORT: begin
        if (cur_i.phase != tpps_pkg::PH_IDLE) begin
          nxt_o.retreat_on  = 1'b0;
          nxt_o.axis_enable = '0;
          nxt_o.phase       = tpps_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase
  end

endmodule
